FILE: src/pcps_pkg.sv
// shared types, widths and helpers for the polyline closest-point search
// used by every module of the block; depends on nothing
package pcps_pkg;

  localparam int MAX_WAYPOINTS = 256;
  localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int FRAC_BITS     = 16;
  localparam int T_BITS        = 16;
  localparam int MIN_LEN_INT   = ((1 << FRAC_BITS) + 9999) / 10000;

  localparam logic [T_BITS:0] T_ONE   = (T_BITS + 1)'(1 << T_BITS);
  localparam logic [31:0]     MIN_LEN = 32'(MIN_LEN_INT);

  // datapath widths
  localparam int D_W    = 33;   // coordinate differences
  localparam int M_W    = 34;   // multiplier operands
  localparam int P_W    = 68;   // multiplier product
  localparam int ACC_W  = 69;   // accumulator
  localparam int LSQ_W  = 66;   // squared segment length
  localparam int RAD_W  = 98;   // root unit radicand
  localparam int ROOT_W = 49;   // root unit result
  localparam int REM_W  = 68;   // divider partial remainder
  localparam int DIV_W  = 67;   // divider divisor
  localparam int QUO_W  = 33;   // divider quotient bits
  localparam int STEP_W = 6;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_AP_WR0,
    OP_RD_LAST,
    OP_AP_DIFF,
    OP_SQ_START_A,
    OP_AP_WR,
    OP_RD_FIRST,
    OP_LOAD_A,
    OP_RD_NEXT,
    OP_LOAD_B,
    OP_SAVE_LSQ,
    OP_T_DECIDE,
    OP_T_FROM_DIV,
    OP_CX,
    OP_CY,
    OP_OXY,
    OP_WIN,
    OP_SQ_START_Q,
    OP_SAVE_LQ,
    OP_LAT_START,
    OP_LAT_DONE,
    OP_ARC_LO,
    OP_ARC,
    OP_ADV,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    MS_NONE,
    MS_DXDX,
    MS_DYDY,
    MS_RXDX,
    MS_RYDY,
    MS_TDX,
    MS_TDY,
    MS_OXOX,
    MS_OYOY,
    MS_DXOY,
    MS_DYOX,
    MS_TLQLO,
    MS_TLQHI
  } msel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    dp_op_t  op;
    msel_t   msel;
    acc_op_t aop;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic count_zero;
    logic count_one;
    logic full;
    logic need_div;
    logic lsq_zero;
    logic better;
    logic last_seg;
    logic div_busy;
    logic sq_busy;
  } dp_stat_t;

  // saturate a sign and magnitude to 32 bits signed
  function automatic logic signed [31:0] sat_s32(input logic neg, input logic big,
                                                 input logic [32:0] m);
    logic signed [31:0] r;
    if (neg) begin
      r = (big || m > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'(~m + 33'd1));
    end else begin
      r = (big || m > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_add_u32(input logic [31:0] a, input logic [34:0] b);
    logic [35:0] s;
    s = 36'(a) + 36'(b);
    return (s > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: src/pcps_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on pcps_pkg
module pcps_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pcps_pkg::REM_W-1:0]   rem_init,
  input  logic [pcps_pkg::DIV_W-1:0]   divisor,
  input  logic [pcps_pkg::QUO_W-1:0]   bits_in,
  input  logic [pcps_pkg::STEP_W-1:0]  steps,
  output logic                         busy,
  output logic [pcps_pkg::QUO_W-1:0]   quot
);
  import pcps_pkg::*;

  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  d_r;
  logic [QUO_W-1:0]  sh_r;
  logic [QUO_W-1:0]  q_r;
  logic [REM_W-1:0]  r2;
  logic              ge;

  assign r2   = {rem_r[REM_W-2:0], sh_r[QUO_W-1]};
  assign ge   = r2 >= REM_W'(d_r);
  assign busy = cnt_r != '0;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= steps;
    end else if (busy) begin
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      d_r   <= divisor;
      sh_r  <= bits_in;
      q_r   <= '0;
    end else if (busy) begin
      rem_r <= ge ? r2 - REM_W'(d_r) : r2;
      sh_r  <= {sh_r[QUO_W-2:0], 1'b0};
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

endmodule

FILE: src/pcps_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
// depends on pcps_pkg
module pcps_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pcps_pkg::RAD_W-1:0]   radicand,
  output logic                         busy,
  output logic [pcps_pkg::ROOT_W-1:0]  root
);
  import pcps_pkg::*;

  localparam int RW = ROOT_W + 3;

  logic [STEP_W-1:0] cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [RW-1:0]     rem_r;
  logic [ROOT_W-1:0] res_r;
  logic [RW-1:0]     r2;
  logic [RW-1:0]     trial;
  logic              ge;

  assign r2    = {rem_r[RW-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = RW'({res_r, 2'b01});
  assign ge    = r2 >= trial;
  assign busy  = cnt_r != '0;
  assign root  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= STEP_W'(ROOT_W);
    end else if (busy) begin
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radicand;
      rem_r <= '0;
      res_r <= '0;
    end else if (busy) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r <= ge ? r2 - trial : r2;
      res_r <= {res_r[ROOT_W-2:0], ge};
    end
  end

endmodule

FILE: src/pcps_dpath.sv
// datapath: waypoint memories, shared multiplier and accumulator, projection regs
// depends on pcps_pkg, pcps_div and pcps_sqrt
module pcps_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcps_pkg::dp_cmd_t                  cmd,
  output pcps_pkg::dp_stat_t                 stat,
  input  logic                               in_func,
  input  logic                               in_clear_first,
  input  logic signed [31:0]                 in_pos_x,
  input  logic signed [31:0]                 in_pos_y,
  output logic                               out_path_ok,
  output logic [8:0]                         out_point_count,
  output logic [31:0]                        out_path_length,
  output logic [7:0]                         out_segment_index,
  output logic [16:0]                        out_seg_fraction,
  output logic signed [31:0]                 out_near_x,
  output logic signed [31:0]                 out_near_y,
  output logic signed [31:0]                 out_lateral_error,
  output logic [31:0]                        out_arc_position
);
  import pcps_pkg::*;

  logic signed [31:0] mem_x [MAX_WAYPOINTS];
  logic signed [31:0] mem_y [MAX_WAYPOINTS];
  logic [31:0]        mem_l [MAX_WAYPOINTS];

  logic               func_r;
  logic signed [31:0] x_r, y_r;
  logic [CNT_W-1:0]   count_r;
  logic [31:0]        plen_r;
  logic signed [31:0] rd_x_r, rd_y_r;
  logic [31:0]        rd_l_r;
  logic signed [31:0] ax_r, ay_r, bx_r, by_r;
  logic [31:0]        alen_r, blen_r;
  logic signed [D_W-1:0] dx_r, dy_r, rx_r, ry_r, ox_r, oy_r;
  logic [ADDR_W-1:0]  i_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [LSQ_W-1:0]   lsq_r;
  logic [T_BITS:0]    t_r, tb_r;
  logic signed [31:0] cx_r, cy_r;
  logic               found_r;
  logic [LSQ_W-1:0]   best_r;
  logic [ADDR_W-1:0]  seg_r;
  logic signed [31:0] nx_r, ny_r, lat_r;
  logic [31:0]        arc_r;
  logic [ROOT_W-1:0]  lq_r;
  logic               cm_neg_r, lat_ovf_r;
  logic [ROOT_W-1:0]  arcp_r;

  logic               out_ok_r;
  logic [8:0]         out_cnt_r;
  logic [31:0]        out_len_r;
  logic [7:0]         out_seg_r;
  logic [16:0]        out_t_r;
  logic signed [31:0] out_nx_r, out_ny_r, out_lat_r;
  logic [31:0]        out_arc_r;

  logic signed [M_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] prod_ext;
  logic                 mem_we;
  logic [31:0]          wr_len;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    last_addr;
  logic                 dot_le0, dot_lt;
  logic signed [33:0]   cx_sum, cy_sum;
  logic [ACC_W-1:0]     cm_abs;
  logic [REM_W-1:0]     cm_mag;
  logic [32:0]          oy_mag;
  logic [34:0]          arc_add;

  logic                 div_start;
  logic [REM_W-1:0]     div_rem;
  logic [DIV_W-1:0]     div_d;
  logic [QUO_W-1:0]     div_bits;
  logic [STEP_W-1:0]    div_steps;
  logic                 div_busy;
  logic [QUO_W-1:0]     div_q;
  logic                 sq_start;
  logic [RAD_W-1:0]     sq_rad;
  logic                 sq_busy;
  logic [ROOT_W-1:0]    sq_root;

  pcps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .divisor  (div_d),
    .bits_in  (div_bits),
    .steps    (div_steps),
    .busy     (div_busy),
    .quot     (div_q)
  );

  pcps_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.msel)
      MS_DXDX:  begin mul_a = M_W'(dx_r); mul_b = M_W'(dx_r); end
      MS_DYDY:  begin mul_a = M_W'(dy_r); mul_b = M_W'(dy_r); end
      MS_RXDX:  begin mul_a = M_W'(rx_r); mul_b = M_W'(dx_r); end
      MS_RYDY:  begin mul_a = M_W'(ry_r); mul_b = M_W'(dy_r); end
      MS_TDX:   begin mul_a = $signed(M_W'(t_r)); mul_b = M_W'(dx_r); end
      MS_TDY:   begin mul_a = $signed(M_W'(t_r)); mul_b = M_W'(dy_r); end
      MS_OXOX:  begin mul_a = M_W'(ox_r); mul_b = M_W'(ox_r); end
      MS_OYOY:  begin mul_a = M_W'(oy_r); mul_b = M_W'(oy_r); end
      MS_DXOY:  begin mul_a = M_W'(dx_r); mul_b = M_W'(oy_r); end
      MS_DYOX:  begin mul_a = M_W'(dy_r); mul_b = M_W'(ox_r); end
      MS_TLQLO: begin mul_a = $signed(M_W'(t_r)); mul_b = $signed(M_W'(lq_r[31:0])); end
      MS_TLQHI: begin
        mul_a = $signed(M_W'(t_r));
        mul_b = $signed(M_W'(lq_r[ROOT_W-1:32]));
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_ext  = ACC_W'(prod_r);
  assign last_addr = ADDR_W'(count_r - CNT_W'(1));
  assign dot_le0   = acc_r[ACC_W-1] || (acc_r == '0);
  assign dot_lt    = acc_r < $signed(ACC_W'(lsq_r));
  assign cx_sum    = 34'(ax_r) + 34'(prod_r >>> T_BITS);
  assign cy_sum    = 34'(ay_r) + 34'(prod_r >>> T_BITS);
  assign cm_abs    = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign cm_mag    = cm_abs[REM_W-1:0];
  assign oy_mag    = oy_r[D_W-1] ? 33'(-oy_r) : 33'(oy_r);
  assign arc_add   = 35'(arcp_r[ROOT_W-1:32]) + 35'(prod_r[33:0]);

  // memory and iterative unit controls
  always_comb begin
    mem_we    = 1'b0;
    wr_len    = '0;
    rd_en     = 1'b1;
    rd_addr   = '0;
    div_start = 1'b0;
    div_rem   = '0;
    div_d     = '0;
    div_bits  = '0;
    div_steps = '0;
    sq_start  = 1'b0;
    sq_rad    = '0;
    unique case (cmd.op)
      OP_AP_WR0: begin
        mem_we = 1'b1;
        wr_len = '0;
      end
      OP_AP_WR: begin
        mem_we = 1'b1;
        wr_len = sat_add_u32(alen_r, 35'(sq_root));
      end
      OP_RD_LAST:  rd_addr = last_addr;
      OP_RD_FIRST: rd_addr = '0;
      OP_RD_NEXT:  rd_addr = i_r + ADDR_W'(1);
      OP_T_DECIDE: begin
        div_start = (lsq_r != '0) && !dot_le0 && dot_lt;
        div_rem   = REM_W'(acc_r[LSQ_W-1:0]);
        div_d     = DIV_W'(lsq_r);
        div_steps = STEP_W'(T_BITS);
      end
      OP_LAT_START: begin
        // quotient of |cross| * 2^16 by lq; upper bits at or above lq are flagged as overflow
        div_start = 1'b1;
        div_rem   = REM_W'(cm_mag[REM_W-1:17]);
        div_d     = DIV_W'(lq_r);
        div_bits  = {cm_mag[16:0], 16'b0};
        div_steps = STEP_W'(QUO_W);
      end
      OP_SQ_START_A: begin
        sq_start = 1'b1;
        sq_rad   = RAD_W'(acc_r[LSQ_W-1:0]);
      end
      OP_SQ_START_Q: begin
        sq_start = 1'b1;
        sq_rad   = {lsq_r, 32'b0};
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[count_r[ADDR_W-1:0]] <= x_r;
      mem_y[count_r[ADDR_W-1:0]] <= y_r;
      mem_l[count_r[ADDR_W-1:0]] <= wr_len;
    end
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
      rd_l_r <= mem_l[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      plen_r  <= '0;
    end else begin
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (!in_func && in_clear_first) begin
            count_r <= '0;
            plen_r  <= '0;
          end
        end
        OP_AP_WR0: begin
          count_r <= count_r + CNT_W'(1);
          plen_r  <= '0;
        end
        OP_AP_WR: begin
          count_r <= count_r + CNT_W'(1);
          plen_r  <= wr_len;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.aop)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_SUB:  acc_r <= acc_r - prod_ext;
      default:  ;
    endcase
    unique case (cmd.op)
      OP_ACCEPT: begin
        func_r <= in_func;
        x_r    <= in_pos_x;
        y_r    <= in_pos_y;
        seg_r  <= '0;
        tb_r   <= '0;
        nx_r   <= '0;
        ny_r   <= '0;
        lat_r  <= '0;
        arc_r  <= '0;
      end
      OP_AP_DIFF: begin
        dx_r   <= D_W'(x_r) - D_W'(rd_x_r);
        dy_r   <= D_W'(y_r) - D_W'(rd_y_r);
        alen_r <= rd_l_r;
      end
      OP_LOAD_A: begin
        ax_r    <= rd_x_r;
        ay_r    <= rd_y_r;
        alen_r  <= rd_l_r;
        nx_r    <= rd_x_r;
        ny_r    <= rd_y_r;
        i_r     <= '0;
        found_r <= 1'b0;
      end
      OP_LOAD_B: begin
        bx_r   <= rd_x_r;
        by_r   <= rd_y_r;
        blen_r <= rd_l_r;
        dx_r   <= D_W'(rd_x_r) - D_W'(ax_r);
        dy_r   <= D_W'(rd_y_r) - D_W'(ay_r);
        rx_r   <= D_W'(x_r) - D_W'(ax_r);
        ry_r   <= D_W'(y_r) - D_W'(ay_r);
      end
      OP_SAVE_LSQ: lsq_r <= acc_r[LSQ_W-1:0];
      OP_T_DECIDE: begin
        if ((lsq_r == '0) || dot_le0) begin
          t_r <= '0;
        end else if (!dot_lt) begin
          t_r <= T_ONE;
        end
      end
      OP_T_FROM_DIV: t_r <= {1'b0, div_q[T_BITS-1:0]};
      OP_CX: cx_r <= cx_sum[31:0];
      OP_CY: cy_r <= cy_sum[31:0];
      OP_OXY: begin
        ox_r <= D_W'(x_r) - D_W'(cx_r);
        oy_r <= D_W'(y_r) - D_W'(cy_r);
      end
      OP_WIN: begin
        found_r <= 1'b1;
        best_r  <= acc_r[LSQ_W-1:0];
        seg_r   <= i_r;
        tb_r    <= t_r;
        nx_r    <= cx_r;
        ny_r    <= cy_r;
        // degenerate segment: direction taken as +x
        if (lsq_r == '0) begin
          lat_r <= sat_s32(oy_r[D_W-1], 1'b0, oy_mag);
          arc_r <= alen_r;
        end
      end
      OP_SAVE_LQ: lq_r <= sq_root;
      OP_LAT_START: begin
        cm_neg_r  <= acc_r[ACC_W-1];
        lat_ovf_r <= cm_mag >= REM_W'({lq_r, 17'b0});
      end
      OP_LAT_DONE: lat_r <= sat_s32(cm_neg_r, lat_ovf_r, div_q);
      OP_ARC_LO:   arcp_r <= prod_r[ROOT_W-1:0];
      OP_ARC:      arc_r  <= sat_add_u32(alen_r, arc_add);
      OP_ADV: begin
        ax_r   <= bx_r;
        ay_r   <= by_r;
        alen_r <= blen_r;
        i_r    <= i_r + ADDR_W'(1);
      end
      OP_EMIT: begin
        out_ok_r  <= (count_r >= CNT_W'(2)) && (plen_r >= MIN_LEN);
        out_cnt_r <= 9'(count_r);
        out_len_r <= plen_r;
        out_seg_r <= 8'(seg_r);
        out_t_r   <= tb_r;
        out_nx_r  <= nx_r;
        out_ny_r  <= ny_r;
        out_lat_r <= lat_r;
        out_arc_r <= arc_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.func       = func_r;
    stat.count_zero = count_r == '0;
    stat.count_one  = count_r == CNT_W'(1);
    stat.full       = count_r == CNT_W'(MAX_WAYPOINTS);
    stat.need_div   = (lsq_r != '0) && !dot_le0 && dot_lt;
    stat.lsq_zero   = lsq_r == '0;
    stat.better     = !found_r || (acc_r[LSQ_W-1:0] < best_r);
    stat.last_seg   = (CNT_W'(i_r) + CNT_W'(2)) == count_r;
    stat.div_busy   = div_busy;
    stat.sq_busy    = sq_busy;
  end

  assign out_path_ok       = out_ok_r;
  assign out_point_count   = out_cnt_r;
  assign out_path_length   = out_len_r;
  assign out_segment_index = out_seg_r;
  assign out_seg_fraction  = out_t_r;
  assign out_near_x        = out_nx_r;
  assign out_near_y        = out_ny_r;
  assign out_lateral_error = out_lat_r;
  assign out_arc_position  = out_arc_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_WAYPOINTS))
    else $error("waypoint count above capacity");

  a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OXY) |-> (t_r <= T_ONE))
    else $error("projection parameter above one");

endmodule

FILE: src/pcps_ctrl.sv
// sequencer for append and query requests, drives datapath commands
// depends on pcps_pkg
module pcps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pcps_pkg::dp_stat_t   stat,
  output pcps_pkg::dp_cmd_t    cmd
);
  import pcps_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH,
    S_AP_WR0, S_AP_RD, S_AP_DIFF, S_AP_M1, S_AP_M2, S_AP_M3, S_AP_SQ, S_AP_SQW, S_AP_WR,
    S_Q_RD0, S_Q_A0, S_Q_RDB, S_Q_B,
    S_Q_M1, S_Q_M2, S_Q_M3, S_Q_M4, S_Q_M5, S_Q_T, S_Q_TDW,
    S_Q_C1, S_Q_C2, S_Q_C3, S_Q_C4, S_Q_D1, S_Q_D2, S_Q_D3, S_Q_CMP,
    S_Q_LQ, S_Q_LQW, S_Q_X1, S_Q_X2, S_Q_X3, S_Q_X4, S_Q_X5, S_Q_X7, S_Q_X8,
    S_Q_NEXT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    cmd.msel  = MS_NONE;
    cmd.aop   = ACC_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.func) begin
          if (stat.full)            state_nxt = S_EMIT;
          else if (stat.count_zero) state_nxt = S_AP_WR0;
          else                      state_nxt = S_AP_RD;
        end else begin
          state_nxt = stat.count_zero ? S_EMIT : S_Q_RD0;
        end
      end
      S_AP_WR0:  begin cmd.op = OP_AP_WR0;  state_nxt = S_EMIT; end
      S_AP_RD:   begin cmd.op = OP_RD_LAST; state_nxt = S_AP_DIFF; end
      S_AP_DIFF: begin cmd.op = OP_AP_DIFF; state_nxt = S_AP_M1; end
      S_AP_M1:   begin cmd.msel = MS_DXDX; state_nxt = S_AP_M2; end
      S_AP_M2:   begin cmd.msel = MS_DYDY; cmd.aop = ACC_LOAD; state_nxt = S_AP_M3; end
      S_AP_M3:   begin cmd.aop = ACC_ADD; state_nxt = S_AP_SQ; end
      S_AP_SQ:   begin cmd.op = OP_SQ_START_A; state_nxt = S_AP_SQW; end
      S_AP_SQW:  if (!stat.sq_busy) state_nxt = S_AP_WR;
      S_AP_WR:   begin cmd.op = OP_AP_WR; state_nxt = S_EMIT; end
      S_Q_RD0:   begin cmd.op = OP_RD_FIRST; state_nxt = S_Q_A0; end
      S_Q_A0: begin
        cmd.op    = OP_LOAD_A;
        state_nxt = stat.count_one ? S_EMIT : S_Q_RDB;
      end
      S_Q_RDB: begin cmd.op = OP_RD_NEXT; state_nxt = S_Q_B; end
      S_Q_B:   begin cmd.op = OP_LOAD_B;  state_nxt = S_Q_M1; end
      S_Q_M1:  begin cmd.msel = MS_DXDX; state_nxt = S_Q_M2; end
      S_Q_M2:  begin cmd.msel = MS_DYDY; cmd.aop = ACC_LOAD; state_nxt = S_Q_M3; end
      S_Q_M3:  begin cmd.msel = MS_RXDX; cmd.aop = ACC_ADD; state_nxt = S_Q_M4; end
      S_Q_M4: begin
        cmd.op    = OP_SAVE_LSQ;
        cmd.msel  = MS_RYDY;
        cmd.aop   = ACC_LOAD;
        state_nxt = S_Q_M5;
      end
      S_Q_M5: begin cmd.aop = ACC_ADD; state_nxt = S_Q_T; end
      S_Q_T: begin
        cmd.op    = OP_T_DECIDE;
        state_nxt = stat.need_div ? S_Q_TDW : S_Q_C1;
      end
      S_Q_TDW: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_T_FROM_DIV;
          state_nxt = S_Q_C1;
        end
      end
      S_Q_C1:  begin cmd.msel = MS_TDX; state_nxt = S_Q_C2; end
      S_Q_C2:  begin cmd.msel = MS_TDY; cmd.op = OP_CX; state_nxt = S_Q_C3; end
      S_Q_C3:  begin cmd.op = OP_CY; state_nxt = S_Q_C4; end
      S_Q_C4:  begin cmd.op = OP_OXY; state_nxt = S_Q_D1; end
      S_Q_D1:  begin cmd.msel = MS_OXOX; state_nxt = S_Q_D2; end
      S_Q_D2:  begin cmd.msel = MS_OYOY; cmd.aop = ACC_LOAD; state_nxt = S_Q_D3; end
      S_Q_D3:  begin cmd.aop = ACC_ADD; state_nxt = S_Q_CMP; end
      S_Q_CMP: begin
        if (stat.better) begin
          cmd.op    = OP_WIN;
          state_nxt = stat.lsq_zero ? S_Q_NEXT : S_Q_LQ;
        end else begin
          state_nxt = S_Q_NEXT;
        end
      end
      S_Q_LQ:  begin cmd.op = OP_SQ_START_Q; state_nxt = S_Q_LQW; end
      S_Q_LQW: if (!stat.sq_busy) state_nxt = S_Q_X1;
      S_Q_X1:  begin cmd.op = OP_SAVE_LQ; cmd.msel = MS_DXOY; state_nxt = S_Q_X2; end
      S_Q_X2:  begin cmd.msel = MS_DYOX; cmd.aop = ACC_LOAD; state_nxt = S_Q_X3; end
      S_Q_X3:  begin cmd.aop = ACC_SUB; state_nxt = S_Q_X4; end
      S_Q_X4:  begin cmd.op = OP_LAT_START; state_nxt = S_Q_X5; end
      S_Q_X5: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_LAT_DONE;
          cmd.msel  = MS_TLQLO;
          state_nxt = S_Q_X7;
        end
      end
      S_Q_X7:  begin cmd.op = OP_ARC_LO; cmd.msel = MS_TLQHI; state_nxt = S_Q_X8; end
      S_Q_X8:  begin cmd.op = OP_ARC; state_nxt = S_Q_NEXT; end
      S_Q_NEXT: begin
        cmd.op    = OP_ADV;
        state_nxt = stat.last_seg ? S_EMIT : S_Q_RDB;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.op == OP_EMIT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> slot_free)
    else $error("result written over a stalled result");

  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_T && stat.need_div) |=> stat.div_busy)
    else $error("divider not started for projection");

  a_sqrt_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_LQ || state_r == S_AP_SQ) |=> stat.sq_busy)
    else $error("root unit not started");

endmodule

FILE: src/polyline_closest_point_search.sv
// top level of the polyline closest-point search
// depends on pcps_pkg, pcps_ctrl and pcps_dpath
//
// One request at a time. An append to a non-empty path spends most of its
// time in the bit-serial square root for the new segment length. A query
// walks the segments in turn, running the 16-step divider for each segment
// whose projection needs it, and for each non-degenerate segment that becomes
// the new closest one a bit-serial root of the scaled length and a 33-step
// divide for the cross-track error. All products go through one shared 34x34
// multiplier and the waypoint memories are read one point per segment. A
// result waits in an output register, so the next request is taken while it
// is held.
module polyline_closest_point_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic               in_clear_first,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_path_ok,
  output logic [8:0]         out_point_count,
  output logic [31:0]        out_path_length,
  output logic [7:0]         out_segment_index,
  output logic [16:0]        out_seg_fraction,
  output logic signed [31:0] out_near_x,
  output logic signed [31:0] out_near_y,
  output logic signed [31:0] out_lateral_error,
  output logic [31:0]        out_arc_position
);
  import pcps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcps_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_clear_first    (in_clear_first),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .out_path_ok       (out_path_ok),
    .out_point_count   (out_point_count),
    .out_path_length   (out_path_length),
    .out_segment_index (out_segment_index),
    .out_seg_fraction  (out_seg_fraction),
    .out_near_x        (out_near_x),
    .out_near_y        (out_near_y),
    .out_lateral_error (out_lateral_error),
    .out_arc_position  (out_arc_position)
  );

endmodule
